// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, held off while reset is low.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/p2c_pkg.sv =====
// ---------------------------------------------------------------------------
// p2c_pkg
// Types, constants and helper functions of the scan polar-to-Cartesian block.
// ---------------------------------------------------------------------------
package p2c_pkg;

	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 1;
	localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP  = 1'd1;

	localparam int COORD_W    = 17;
	localparam int SCAN_W     = 32;
	localparam int GUARD_BITS = 16;
	localparam int OUT_LIMIT  = 65535;
	localparam int M_DATA_W   = 72;   // x, y, scan number, padded to bytes

	localparam int ARC_LEN    = 24;
	localparam int ARC_IDX_W  = 5;
	localparam int Z_W        = 34;

	// atan(2^-i) as 32-bit binary angles, truncated
	localparam logic [31:0] ARC_TABLE [ARC_LEN] = '{
		32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
		32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
	};

	typedef struct packed {
		logic busy;
		logic done;
	} cordic_stat_t;

	// CORDIC gain correction in Q0.32, worked out at elaboration
	function automatic logic [31:0] gain_q32(input int steps);
		logic [63:0] p;
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] b;
		logic [63:0] rem;
		logic [63:0] q;
		int k;
		p = 64'd1 << 60;
		for (k = 0; k < steps; k++) begin
			p = p + (p >> (2 * k));
		end
		// integer square root, bit by bit
		v   = p;
		res = '0;
		b   = 64'd1 << 62;
		for (k = 0; k < 32; k++) begin
			if (b > v) begin
				b = b >> 2;
			end
		end
		for (k = 0; k < 32; k++) begin
			if (b != 0) begin
				if (v >= res + b) begin
					v   = v - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
		end
		// restoring long division of 2^62 by the root
		rem = '0;
		q   = '0;
		for (k = 62; k >= 0; k--) begin
			rem = {rem[62:0], (k == 62) ? 1'b1 : 1'b0};
			if (rem >= res) begin
				rem  = rem - res;
				q[k] = 1'b1;
			end
		end
		return q[31:0];
	endfunction

	// round half up at the guard bits, then clamp to the output range
	function automatic logic [COORD_W-1:0] round_sat(input logic signed [63:0] v);
		logic signed [63:0] r;
		r = (v + (64'sd1 <<< (GUARD_BITS - 1))) >>> GUARD_BITS;
		if (r > 64'(OUT_LIMIT)) begin
			r = 64'(OUT_LIMIT);
		end else if (r < -64'(OUT_LIMIT)) begin
			r = -64'(OUT_LIMIT);
		end
		return r[COORD_W-1:0];
	endfunction

endpackage

// ===== rtl/p2c_scan_track.sv =====
// ---------------------------------------------------------------------------
// p2c_scan_track
// Configuration registers, running sample angle and scan counter.
// ---------------------------------------------------------------------------
module p2c_scan_track #(
	parameter int ANGLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [p2c_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [p2c_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                          take,       // item accepted
	input  logic                          take_last,  // accepted item closes its scan
	output logic [ANGLE_BITS-1:0]         cur_angle,
	output logic [p2c_pkg::SCAN_W-1:0]    cur_scan
);

	logic [p2c_pkg::CFG_W-1:0]  start_angle_q;
	logic [p2c_pkg::CFG_W-1:0]  angle_step_q;
	logic [ANGLE_BITS-1:0]      next_angle_q;
	logic                       at_start_q;
	logic [p2c_pkg::SCAN_W-1:0] scan_count_q;
	logic signed [31:0]         start_ext;
	logic signed [31:0]         step_ext;

	assign start_ext = 32'(signed'(start_angle_q));
	assign step_ext  = 32'(signed'(angle_step_q));

	assign cur_angle = at_start_q ? start_ext[ANGLE_BITS-1:0] : next_angle_q;
	assign cur_scan  = at_start_q ? scan_count_q + 1'b1 : scan_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_angle_q <= '0;
			angle_step_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				p2c_pkg::REG_START_ANGLE: start_angle_q <= cfg_wdata;
				p2c_pkg::REG_ANGLE_STEP:  angle_step_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_angle_q <= '0;
			at_start_q   <= 1'b1;
			scan_count_q <= '0;
		end else if (take) begin
			next_angle_q <= cur_angle + step_ext[ANGLE_BITS-1:0];
			at_start_q   <= take_last;
			scan_count_q <= cur_scan;
		end
	end

endmodule

// ===== rtl/p2c_cordic.sv =====
// ---------------------------------------------------------------------------
// p2c_cordic
// Iterative rotation unit: gain-corrected start vector, quadrant fold, then
// one micro-rotation a cycle through a shared shift-and-add datapath.
// ---------------------------------------------------------------------------
module p2c_cordic #(
	parameter int ROTATION_STEPS = 16,
	parameter int RANGE_BITS     = 16,
	parameter int ANGLE_BITS     = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [RANGE_BITS-1:0]         range_in,
	input  logic [ANGLE_BITS-1:0]         angle_in,
	input  logic                          ack,        // result taken in DONE
	output p2c_pkg::cordic_stat_t         stat,
	output logic signed [RANGE_BITS+18:0] x_out,
	output logic signed [RANGE_BITS+18:0] y_out
);

	localparam int XW = RANGE_BITS + 19;
	localparam logic [31:0] GAIN = p2c_pkg::gain_q32(ROTATION_STEPS);
	localparam logic [p2c_pkg::ARC_IDX_W-1:0] LAST_IT =
		p2c_pkg::ARC_IDX_W'(ROTATION_STEPS - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_ROT  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]                        state_q;
	logic [p2c_pkg::ARC_IDX_W-1:0]     it_q;
	logic [RANGE_BITS-1:0]             range_q;
	logic [31:0]                       theta_q;
	logic signed [XW-1:0]              x_q;
	logic signed [XW-1:0]              y_q;
	logic signed [p2c_pkg::Z_W-1:0]    z_q;

	logic [31:0]                       theta_in;
	logic                              fold;
	logic [RANGE_BITS+31:0]            prod;
	logic signed [XW-1:0]              x0;
	logic signed [XW-1:0]              dx;
	logic signed [XW-1:0]              dy;
	logic signed [p2c_pkg::Z_W-1:0]    arc;

	assign theta_in = 32'(angle_in) << (32 - ANGLE_BITS);
	// second and third quadrant: rotate by pi and negate the start vector
	assign fold     = theta_q[31] ^ theta_q[30];
	assign prod     = (RANGE_BITS + 32)'(range_q) * (RANGE_BITS + 32)'(GAIN);
	assign x0       = $signed({3'b000, prod[RANGE_BITS+31:p2c_pkg::GUARD_BITS]});
	assign dx       = y_q >>> it_q;
	assign dy       = x_q >>> it_q;
	assign arc      = $signed(p2c_pkg::Z_W'(p2c_pkg::ARC_TABLE[it_q]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			it_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_ROT;
					it_q    <= '0;
				end
				ST_ROT: begin
					if (it_q == LAST_IT) begin
						state_q <= ST_DONE;
					end else begin
						it_q <= it_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (ack) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			range_q <= range_in;
			theta_q <= theta_in;
		end
		if (state_q == ST_MUL) begin
			x_q <= fold ? -x0 : x0;
			y_q <= '0;
			z_q <= p2c_pkg::Z_W'(signed'({~theta_q[31] ^ theta_q[30] ? theta_q[31] : ~theta_q[31],
				theta_q[30:0]}));
		end else if (state_q == ST_ROT) begin
			if (!z_q[p2c_pkg::Z_W-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - arc;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + arc;
			end
		end
	end

	assign stat.busy = (state_q != ST_IDLE);
	assign stat.done = (state_q == ST_DONE);
	assign x_out     = x_q;
	assign y_out     = y_q;

endmodule

// ===== rtl/scan_polar_to_cartesian.sv =====
// ---------------------------------------------------------------------------
// scan_polar_to_cartesian
// Converts laser scan range samples to Cartesian points with an iterative
// gain-corrected CORDIC; tracks sample angle and scan number.
// ---------------------------------------------------------------------------
//  channel   signals                        carries
//  s_*       s_tvalid s_tready s_tdata      range_sample; s_tlast = scan_end
//  m_*       m_tvalid m_tready m_tdata      point_x, point_y, scan_number;
//                                           m_tlast = final_point
//  cfg_*     cfg_we cfg_index cfg_wdata     0 start_angle, 1 angle_step
//
//  An item passes through load, gain multiply, one CORDIC micro-rotation per
//  cycle, then the output register. s_tready is high only while the rotation
//  unit is free; a new item is taken while a finished point still waits on
//  m_*, and the unit holds its result until the output register is free.
//  Reset clears scan state and configuration registers.
// ---------------------------------------------------------------------------
module scan_polar_to_cartesian #(
	parameter int ROTATION_STEPS = 16,
	parameter int RANGE_BITS     = 16,
	parameter int ANGLE_BITS     = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [((RANGE_BITS+7)/8)*8-1:0] s_tdata,  // [RANGE_BITS-1:0] range_sample
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [p2c_pkg::M_DATA_W-1:0]  m_tdata,    // point_x, point_y, scan_number
	output logic                          m_tlast,
	input  logic                          cfg_we,
	input  logic [p2c_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [p2c_pkg::CFG_W-1:0]     cfg_wdata
);

	localparam int XW = RANGE_BITS + 19;
	localparam int PAD_W = p2c_pkg::M_DATA_W - 2 * p2c_pkg::COORD_W - p2c_pkg::SCAN_W;

	p2c_pkg::cordic_stat_t              stat;
	logic                               take;
	logic                               ack;
	logic [ANGLE_BITS-1:0]              cur_angle;
	logic [p2c_pkg::SCAN_W-1:0]         cur_scan;
	logic signed [XW-1:0]               x_raw;
	logic signed [XW-1:0]               y_raw;

	logic [p2c_pkg::SCAN_W-1:0]         scan_q;
	logic                               last_q;
	logic                               out_valid_q;
	logic [p2c_pkg::COORD_W-1:0]        out_x_q;
	logic [p2c_pkg::COORD_W-1:0]        out_y_q;
	logic [p2c_pkg::SCAN_W-1:0]         out_scan_q;
	logic                               out_last_q;

	assign s_tready = !stat.busy;
	assign take     = s_tvalid && s_tready;
	assign ack      = stat.done && (!out_valid_q || m_tready);

	p2c_scan_track #(
		.ANGLE_BITS(ANGLE_BITS)
	) u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.take      (take),
		.take_last (s_tlast),
		.cur_angle (cur_angle),
		.cur_scan  (cur_scan)
	);

	p2c_cordic #(
		.ROTATION_STEPS(ROTATION_STEPS),
		.RANGE_BITS    (RANGE_BITS),
		.ANGLE_BITS    (ANGLE_BITS)
	) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (take),
		.range_in (s_tdata[RANGE_BITS-1:0]),
		.angle_in (cur_angle),
		.ack      (ack),
		.stat     (stat),
		.x_out    (x_raw),
		.y_out    (y_raw)
	);

	// item tags ride alongside the rotation
	always_ff @(posedge clk) begin
		if (take) begin
			scan_q <= cur_scan;
			last_q <= s_tlast;
		end
		if (ack) begin
			out_x_q    <= p2c_pkg::round_sat(64'(x_raw));
			out_y_q    <= p2c_pkg::round_sat(64'(y_raw));
			out_scan_q <= scan_q;
			out_last_q <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ack) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_scan_q, out_y_q, out_x_q};
	assign m_tlast  = out_last_q;

endmodule

// ===== rtl/p2c_checker.sv =====
// ---------------------------------------------------------------------------
// p2c_checker
// Port-level checks on the scan polar-to-Cartesian block, bound to the top.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module p2c_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [p2c_pkg::M_DATA_W-1:0] m_tdata
);

	logic s_take;
	assign s_take = s_tvalid && s_tready;

	// one item at a time: no second item right behind the first
	`ASSERT_NEXT(a_busy_after_take, clk, arst_n, s_take, !s_tready, "ready after accept")
	// a point never shows up in the cycle after an item was accepted
	`ASSERT_IMPLY(a_no_instant_out, clk, arst_n, $rose(m_tvalid), !$past(s_take), "early point")
	`ASSERT_NEXT(a_out_held, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
		"stalled point changed")
	// saturation keeps both coordinates off the most negative code
	`ASSERT_IMPLY(a_sat, clk, arst_n, m_tvalid,
		m_tdata[16:0] != 17'h10000 && m_tdata[33:17] != 17'h10000, "coordinate out of range")
	`ASSERT_IMPLY(a_pad, clk, arst_n, m_tvalid, m_tdata[71:66] == 6'd0, "padding not zero")

endmodule

bind scan_polar_to_cartesian p2c_checker u_p2c_checker (.*);
